### rtl/sli_pkg.sv
// Shared constants, codes and types for the sorted list insert/delete unit.
package sli_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Operation codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_DELETED   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Index register operations
    localparam logic [2:0] IDX_HOLD  = 3'd0;
    localparam logic [2:0] IDX_ZERO  = 3'd1;
    localparam logic [2:0] IDX_COUNT = 3'd2;
    localparam logic [2:0] IDX_INC   = 3'd3;
    localparam logic [2:0] IDX_DEC   = 3'd4;

    // Read address selection, relative to the index register
    localparam logic [1:0] RD_CUR = 2'd0;
    localparam logic [1:0] RD_DEC = 2'd1;
    localparam logic [1:0] RD_INC = 2'd2;

    // Write data selection
    localparam logic WR_VALUE = 1'b0;
    localparam logic WR_RDATA = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic [CNT_W-1:0]         entry_count;
        logic                     head_valid;
        logic signed [DATA_W-1:0] head_value;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic       accept;
        logic [2:0] idx_op;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic       wr_sel;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       load_out;
        logic [1:0] out_status;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_del;
        logic full;
        logic idx_zero;
        logic idx_at_top;
        logic idx_last;
        logic less;
        logic equal;
        logic out_free;
    } t_dp_stat;

endpackage

### rtl/sorted_list_insert_delete_unit.sv
// Top level of the sorted list insert/delete unit.
//
// Keeps up to DEPTH signed 32-bit values in ascending order in a RAM.
// Input channel (i_in_valid / o_in_ready / i_in_item): one item is an insert
// or delete command with its value. Output channel (o_out_valid / i_out_ready
// / o_out_item): exactly one result item per input item, in order, giving the
// status, the entry count afterward and the smallest stored value.
// Items are handled one at a time. The controller walks the table through the
// RAM's single registered read port, a read state and an evaluate state per
// visited entry. An insert visits the entries at or above the insert point;
// a delete visits entries from the bottom up to the first one not smaller
// and, on a match, shifts the later ones down; an insert into a full table
// is rejected without a walk. That walk sets the rate at which items are taken.
// The result sits in an output register; a new item is taken while it
// waits, but the next result is held back until the receiver takes the
// previous one, so a stalled receiver blocks at most one item in flight.
// Reset empties the table at once (count to zero, no clearing pass) and
// drops any pending result.
module sorted_list_insert_delete_unit
    import sli_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_ctrl_cmd         cmd;
    t_dp_stat          stat;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    // Sequence the search and shift steps
    sli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Hold the item, index, count, head copy and result register
    sli_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Sorted entry storage; slots at or above the count are never read
    sli_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

### rtl/sli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sli_ctrl.sv
// Sequencer for the sorted list: search, shift and result handoff.
module sli_ctrl
    import sli_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_INS_RD = 4'd2;
    localparam logic [3:0] S_INS_EV = 4'd3;
    localparam logic [3:0] S_DEL_RD = 4'd4;
    localparam logic [3:0] S_DEL_EV = 4'd5;
    localparam logic [3:0] S_SH_RD  = 4'd6;
    localparam logic [3:0] S_SH_EV  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_res, n_res;
    t_ctrl_cmd  cmd;

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_stat.is_del) begin
                    cmd.idx_op = IDX_ZERO;
                    n_state    = S_DEL_RD;
                end else if (i_stat.full) begin
                    n_res   = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    cmd.idx_op = IDX_COUNT;
                    n_state    = S_INS_RD;
                end
            end
            // Walk down from the top, moving larger-or-equal entries up one slot
            S_INS_RD: begin
                if (i_stat.idx_zero) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_VALUE;
                    cmd.cnt_inc = 1'b1;
                    n_res       = ST_INSERTED;
                    n_state     = S_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_DEC;
                    n_state    = S_INS_EV;
                end
            end
            S_INS_EV: begin
                cmd.wr_en = 1'b1;
                if (i_stat.less) begin
                    cmd.wr_sel  = WR_VALUE;
                    cmd.cnt_inc = 1'b1;
                    n_res       = ST_INSERTED;
                    n_state     = S_DONE;
                end else begin
                    cmd.wr_sel = WR_RDATA;
                    cmd.idx_op = IDX_DEC;
                    n_state    = S_INS_RD;
                end
            end
            // Walk up from the bottom until an entry is not smaller
            S_DEL_RD: begin
                if (i_stat.idx_at_top) begin
                    n_res   = ST_NOT_FOUND;
                    n_state = S_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CUR;
                    n_state    = S_DEL_EV;
                end
            end
            S_DEL_EV: begin
                if (i_stat.less) begin
                    cmd.idx_op = IDX_INC;
                    n_state    = S_DEL_RD;
                end else if (i_stat.equal) begin
                    n_state = S_SH_RD;
                end else begin
                    n_res   = ST_NOT_FOUND;
                    n_state = S_DONE;
                end
            end
            // Close the gap: move each later entry down one slot
            S_SH_RD: begin
                if (i_stat.idx_last) begin
                    cmd.cnt_dec = 1'b1;
                    n_res       = ST_DELETED;
                    n_state     = S_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_INC;
                    n_state    = S_SH_EV;
                end
            end
            S_SH_EV: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_RDATA;
                cmd.idx_op = IDX_INC;
                n_state    = S_SH_RD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    cmd.load_out   = 1'b1;
                    cmd.out_status = r_res;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= ST_INSERTED;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.rd_en && o_cmd.wr_en))
        else $error("read and write issued in the same cycle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_stat.out_free)
        else $error("result loaded over an untaken result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START && !i_stat.is_del && i_stat.full) |=>
            (r_state == S_DONE && r_res == ST_FULL))
        else $error("insert into a full table did not reject");

endmodule

### rtl/sli_dp.sv
// Datapath: item latch, index and count registers, compare, head copy, result register.
module sli_dp
    import sli_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_item          i_in_item,
    input  t_ctrl_cmd         i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output t_out_item         o_out_item,
    output logic              o_ram_we,
    output logic [ADDR_W-1:0] o_ram_waddr,
    output logic [DATA_W-1:0] o_ram_wdata,
    output logic              o_ram_re,
    output logic [ADDR_W-1:0] o_ram_raddr,
    input  logic [DATA_W-1:0] i_ram_rdata
);

    t_in_item          r_item;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_head;
    t_out_item         r_out;
    logic              r_out_valid;
    logic [CNT_W-1:0]  idx_m1, idx_p1, rd_idx;
    logic [DATA_W-1:0] wdata;

    assign idx_m1 = r_idx - CNT_W'(1);
    assign idx_p1 = r_idx + CNT_W'(1);

    always_comb begin
        case (i_cmd.idx_op)
            IDX_ZERO:  n_idx = '0;
            IDX_COUNT: n_idx = r_count;
            IDX_INC:   n_idx = idx_p1;
            IDX_DEC:   n_idx = idx_m1;
            default:   n_idx = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_DEC:  rd_idx = idx_m1;
            RD_INC:  rd_idx = idx_p1;
            default: rd_idx = r_idx;
        endcase
    end

    assign wdata = (i_cmd.wr_sel == WR_RDATA) ? i_ram_rdata : r_item.value;

    assign o_ram_we    = i_cmd.wr_en;
    assign o_ram_waddr = r_idx[ADDR_W-1:0];
    assign o_ram_wdata = wdata;
    assign o_ram_re    = i_cmd.rd_en;
    assign o_ram_raddr = rd_idx[ADDR_W-1:0];

    always_comb begin
        o_stat            = '0;
        o_stat.is_del     = (r_item.cmd == CMD_DELETE);
        o_stat.full       = (r_count == CNT_W'(DEPTH));
        o_stat.idx_zero   = (r_idx == '0);
        o_stat.idx_at_top = (r_idx == r_count);
        o_stat.idx_last   = (idx_p1 == r_count);
        o_stat.less       = ($signed(i_ram_rdata) < r_item.value);
        o_stat.equal      = (i_ram_rdata == r_item.value);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_item;
        end
        r_idx <= n_idx;
        if (i_cmd.wr_en && r_idx == '0) begin
            r_head <= wdata;
        end
        if (i_cmd.load_out) begin
            r_out.status      <= i_cmd.out_status;
            r_out.entry_count <= r_count;
            r_out.head_valid  <= (r_count != '0);
            r_out.head_value  <= (r_count != '0) ? r_head : '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.head_valid == (r_out.entry_count != '0)))
        else $error("head valid disagrees with entry count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("waiting result changed or dropped");

endmodule
